>>> src/total_order_multicast_sequencer_unit_assert.svh
// Assertion macros shared by the sequencer RTL.
`ifndef TOTAL_ORDER_MULTICAST_SEQUENCER_UNIT_ASSERT_SVH
`define TOTAL_ORDER_MULTICAST_SEQUENCER_UNIT_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define TOMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked at every clock edge out of reset.
`define TOMS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> src/toms_pkg.sv
package toms_pkg;

    // input operations
    localparam logic [2:0] OP_SEND  = 3'd0;
    localparam logic [2:0] OP_DATA  = 3'd1;
    localparam logic [2:0] OP_ACK   = 3'd2;
    localparam logic [2:0] OP_FINAL = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_DATA    = 3'd0;
    localparam logic [2:0] KIND_ACK     = 3'd1;
    localparam logic [2:0] KIND_FINAL   = 3'd2;
    localparam logic [2:0] KIND_RETRANS = 3'd3;
    localparam logic [2:0] KIND_DELIVER = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_NODE  = 2'd0;
    localparam logic [1:0] CFG_GROUP     = 2'd1;
    localparam logic [1:0] CFG_QUOTA     = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  peer;
        logic [9:0]  message_number;
        logic [31:0] sequence_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [3:0]  target_node;
        logic [9:0]  result_message;
        logic [31:0] result_sequence;
        logic [15:0] missing_mask;
        logic        queue_overflow;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        logic        deliverable;
        logic [31:0] seq;
        logic [3:0]  sender;
        logic [9:0]  msg;
    } t_hold_entry;

endpackage

>>> src/total_order_multicast_sequencer_unit.sv
// Ordering engine of one node in an ISIS-style total-order multicast group. Each input
// beat is one event (send, data, ack, final-seq, retransmit tick) and yields zero or more
// result beats, the last one flagged. The block works on one event at a time and takes no
// new input beat while it works on the last one. A send and a new data message each sweep
// the hold-back memory once; a final-seq event sweeps the hold-back memory again for every
// delivery, each time for the smallest (sequence, sender) key, and the ack that completes
// a round adds a sweep of the proposal memory. A duplicate data message yields nothing.
// A stalled output holds the block until the waiting result beat is taken.
// After reset the duplicate history memory is cleared one entry a cycle, all
// MAX_NODES*MAX_MESSAGES entries, before the first input beat is taken;
// configuration writes are taken at any time.
`include "total_order_multicast_sequencer_unit_assert.svh"

module total_order_multicast_sequencer_unit #(
    parameter int MAX_NODES    = 16,
    parameter int HOLD_DEPTH   = 32,
    parameter int MAX_MESSAGES = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  toms_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output toms_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [9:0]           i_cfg_data
);

    localparam int NAW        = $clog2(MAX_NODES);
    localparam int HAW        = $clog2(HOLD_DEPTH);
    localparam int HIST_DEPTH = MAX_NODES * MAX_MESSAGES;
    localparam int SAW        = $clog2(HIST_DEPTH);
    localparam int SCAN_MAX   = (HOLD_DEPTH > MAX_NODES) ? HOLD_DEPTH : MAX_NODES;
    localparam int CW         = $clog2(SCAN_MAX + 1);
    localparam int TW         = $clog2(MAX_NODES + 1);
    localparam int MW         = (MAX_NODES < 16) ? MAX_NODES : 16;
    localparam int HEW        = $bits(toms_pkg::t_hold_entry);
    localparam int OW         = $bits(toms_pkg::t_out_item);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HIST, S_ACKSCAN, S_HSCAN, S_HWRITE, S_DSCAN, S_DEMIT, S_FLUSH
    } t_state;

    t_state r_state;

    // configuration
    logic [3:0]  r_own;
    logic [4:0]  r_group;
    logic [9:0]  r_quota;

    // scalar protocol state
    logic [31:0]          r_latest;
    logic [9:0]           r_own_count;
    logic                 r_may_orig;
    logic                 r_awaiting;
    logic [MAX_NODES-1:0] r_ack_seen;
    logic [TW-1:0]        r_ack_total;
    logic [HOLD_DEPTH-1:0] r_hvalid;

    // current event
    logic [2:0]  r_op;
    logic [3:0]  r_peer;
    logic [9:0]  r_msg;
    logic [31:0] r_val;
    logic [SAW-1:0] r_hist_addr;
    logic        r_ok;
    logic        r_any_deliv;

    // hold-back key under work
    logic [31:0] r_key_seq;
    logic [3:0]  r_key_snd;
    logic [9:0]  r_key_msg;
    logic        r_key_del;
    logic        r_do_remove;

    // sweep control
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_rd_idx;
    logic          r_rdv;
    logic [SAW-1:0] r_clr;

    // sweep findings
    logic           r_m_found, r_f_found, r_r_found, r_b_found;
    logic [HAW-1:0] r_m_idx, r_f_idx, r_r_idx, r_b_idx;
    logic [31:0]    r_r_seq, r_b_seq, r_best;
    logic [3:0]     r_b_snd;
    logic [9:0]     r_b_msg;
    logic           r_b_del;

    // result staging: one result held back to learn whether it is the last
    logic                r_pend_valid;
    toms_pkg::t_out_item r_pend;
    logic                r_out_valid;
    toms_pkg::t_out_item r_out;

    // memory ports
    logic           hold_we;
    logic [HAW-1:0] hold_waddr;
    logic [HEW-1:0] hold_wdata, hold_rdata;
    logic           seen_we;
    logic [SAW-1:0] seen_waddr, seen_raddr;
    logic           seen_wdata;
    logic [0:0]     seen_rdata;
    logic           ack_we;
    logic [31:0]    ack_rdata;

    // combinational helpers
    logic           in_acc;
    logic [31:0]    pv, mv;
    logic [NAW-1:0] peer_idx;
    logic           seen_p;
    logic [TW-1:0]  n_total;
    logic [TW-1:0]  eff_g;
    logic           ack_fire;
    logic [15:0]    miss_mask;
    toms_pkg::t_hold_entry hd;
    logic [HAW-1:0] hj;
    logic           vj;
    logic [31:0]    ack_best_c;
    logic [CW-1:0]  scan_len;
    logic           issue, scan_last;
    logic           ok_c;
    logic [HAW-1:0] slot_c;
    logic           can_emit, out_free;
    logic           out_load;
    logic [HOLD_DEPTH-1:0] hv_wr;

    function automatic toms_pkg::t_out_item mk_res(
        input logic [2:0] kind, input logic [3:0] tgt, input logic [9:0] msg,
        input logic [31:0] seq, input logic [15:0] mask, input logic ovf);
        toms_pkg::t_out_item r;
        r.result_kind     = kind;
        r.target_node     = tgt;
        r.result_message  = msg;
        r.result_sequence = seq;
        r.missing_mask    = mask;
        r.queue_overflow  = ovf;
        r.last_result     = 1'b0;
        return r;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign can_emit    = !r_pend_valid || out_free;

    // load the output register this cycle
    assign out_load = ((r_state == S_DEMIT) && r_b_found && r_b_del && can_emit && r_pend_valid)
                      || ((r_state == S_FLUSH) && r_pend_valid && out_free);

    // reduce peer and message to store indexes
    always_comb begin
        pv = 32'(i_in_data.peer);
        for (int k = 2; k >= 0; k--) begin
            if (pv >= (32'(MAX_NODES) << k)) pv = pv - (32'(MAX_NODES) << k);
        end
        mv = 32'(i_in_data.message_number);
        for (int k = 5; k >= 0; k--) begin
            if (mv >= (32'(MAX_MESSAGES) << k)) mv = mv - (32'(MAX_MESSAGES) << k);
        end
    end
    assign peer_idx   = pv[NAW-1:0];
    assign seen_raddr = SAW'(pv * 32'(MAX_MESSAGES) + mv);

    // clamp group size and count acks
    always_comb begin
        if (r_group < 5'd2) eff_g = TW'(2);
        else if (32'(r_group) > 32'(MAX_NODES)) eff_g = TW'(MAX_NODES);
        else eff_g = TW'(r_group);
    end
    assign seen_p   = r_ack_seen[peer_idx];
    assign n_total  = r_ack_total + TW'(!seen_p);
    assign ack_fire = (32'(n_total) + 32'd1) >= 32'(eff_g);

    // nodes still missing an ack
    always_comb begin
        miss_mask = '0;
        for (int p = 0; p < MW; p++) begin
            if ((32'(p) < 32'(eff_g)) && (4'(p) != r_own) && !r_ack_seen[p]) begin
                miss_mask[p] = 1'b1;
            end
        end
    end

    // sweep datapath
    assign hd         = toms_pkg::t_hold_entry'(hold_rdata);
    assign hj         = r_rd_idx[HAW-1:0];
    assign vj         = r_hvalid[hj];
    assign scan_len   = (r_state == S_ACKSCAN) ? CW'(MAX_NODES) : CW'(HOLD_DEPTH);
    assign issue      = r_cnt < scan_len;
    assign scan_last  = r_rdv && (r_rd_idx == scan_len - CW'(1));
    assign ack_best_c = (r_rdv && r_ack_seen[r_rd_idx[NAW-1:0]] && ack_rdata > r_best)
                        ? ack_rdata : r_best;

    // pick the hold-back slot for the key
    always_comb begin
        ok_c   = 1'b1;
        slot_c = r_m_idx;
        if (r_m_found) slot_c = r_m_idx;
        else if (r_f_found) slot_c = r_f_idx;
        else if (r_r_found) slot_c = r_r_idx;
        else ok_c = 1'b0;
    end

    // valid bits after removing the old entry and storing the key
    always_comb begin
        hv_wr = r_hvalid;
        if (r_r_found) hv_wr[r_r_idx] = 1'b0;
        if (ok_c) hv_wr[slot_c] = 1'b1;
    end

    // memory port drive
    assign hold_we    = (r_state == S_HWRITE) && ok_c;
    assign hold_waddr = slot_c;
    assign hold_wdata = HEW'({r_key_del, r_key_seq, r_key_snd, r_key_msg});
    assign seen_we    = (r_state == S_CLEAR) || ((r_state == S_HIST) && !seen_rdata[0]);
    assign seen_waddr = (r_state == S_CLEAR) ? r_clr : r_hist_addr;
    assign seen_wdata = (r_state != S_CLEAR);
    assign ack_we     = in_acc && (i_in_data.operation == toms_pkg::OP_ACK) && r_awaiting
                        && !seen_p;

    toms_ram #(.WIDTH(HEW), .DEPTH(HOLD_DEPTH)) u_hold_ram (
        .i_clk   (i_clk),
        .i_we    (hold_we),
        .i_waddr (hold_waddr),
        .i_wdata (hold_wdata),
        .i_raddr (r_cnt[HAW-1:0]),
        .o_rdata (hold_rdata)
    );

    toms_ram #(.WIDTH(1), .DEPTH(HIST_DEPTH)) u_seen_ram (
        .i_clk   (i_clk),
        .i_we    (seen_we),
        .i_waddr (seen_waddr),
        .i_wdata (seen_wdata),
        .i_raddr (seen_raddr),
        .o_rdata (seen_rdata)
    );

    toms_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_ack_ram (
        .i_clk   (i_clk),
        .i_we    (ack_we),
        .i_waddr (peer_idx),
        .i_wdata (i_in_data.sequence_value),
        .i_raddr (r_cnt[NAW-1:0]),
        .o_rdata (ack_rdata)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_own        <= '0;
            r_group      <= 5'd2;
            r_quota      <= '0;
            r_latest     <= '0;
            r_own_count  <= '0;
            r_may_orig   <= 1'b1;
            r_awaiting   <= 1'b0;
            r_ack_seen   <= '0;
            r_ack_total  <= '0;
            r_hvalid     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_rdv        <= 1'b0;
            r_cnt        <= '0;
        end else begin
            // configuration beats
            if (i_cfg_valid) begin
                if (i_cfg_index == toms_pkg::CFG_OWN_NODE) r_own <= i_cfg_data[3:0];
                else if (i_cfg_index == toms_pkg::CFG_GROUP) r_group <= i_cfg_data[4:0];
                else if (i_cfg_index == toms_pkg::CFG_QUOTA) r_quota <= i_cfg_data;
            end

            // drop the output beat once taken
            if (r_out_valid && i_out_ready && !out_load) r_out_valid <= 1'b0;

            // advance the memory sweep
            if (r_state == S_ACKSCAN || r_state == S_HSCAN || r_state == S_DSCAN) begin
                if (issue) r_cnt <= r_cnt + CW'(1);
                r_rdv    <= issue;
                r_rd_idx <= r_cnt;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + SAW'(1);
                    if (32'(r_clr) == HIST_DEPTH - 1) r_state <= S_IDLE;
                end

                S_IDLE: begin
                    r_m_found   <= 1'b0;
                    r_f_found   <= 1'b0;
                    r_r_found   <= 1'b0;
                    r_b_found   <= 1'b0;
                    r_cnt       <= '0;
                    r_rdv       <= 1'b0;
                    r_best      <= '0;
                    r_any_deliv <= 1'b0;
                    r_ok        <= 1'b1;
                    r_do_remove <= 1'b0;
                    if (in_acc) begin
                        r_op        <= i_in_data.operation;
                        r_peer      <= i_in_data.peer;
                        r_msg       <= i_in_data.message_number;
                        r_val       <= i_in_data.sequence_value;
                        r_hist_addr <= seen_raddr;
                        unique case (i_in_data.operation)
                            toms_pkg::OP_SEND: begin
                                if (r_own_count < r_quota && r_may_orig) begin
                                    r_own_count <= r_own_count + 10'd1;
                                    r_latest    <= r_latest + 32'd1;
                                    r_may_orig  <= 1'b0;
                                    r_awaiting  <= 1'b1;
                                    r_key_seq   <= r_latest + 32'd1;
                                    r_key_snd   <= r_own;
                                    r_key_msg   <= r_own_count + 10'd1;
                                    r_key_del   <= 1'b0;
                                    r_state     <= S_HSCAN;
                                end
                            end
                            toms_pkg::OP_DATA: begin
                                r_state <= S_HIST;
                            end
                            toms_pkg::OP_ACK: begin
                                if (r_awaiting) begin
                                    if (!seen_p) begin
                                        r_ack_seen[peer_idx] <= 1'b1;
                                        r_ack_total          <= n_total;
                                    end
                                    if (ack_fire) r_state <= S_ACKSCAN;
                                end
                            end
                            toms_pkg::OP_FINAL: begin
                                r_key_seq   <= i_in_data.sequence_value;
                                r_key_snd   <= i_in_data.peer;
                                r_key_msg   <= i_in_data.message_number;
                                r_key_del   <= 1'b1;
                                r_do_remove <= 1'b1;
                                r_state     <= S_HSCAN;
                            end
                            toms_pkg::OP_TICK: begin
                                if (r_awaiting) begin
                                    r_pend <= mk_res(toms_pkg::KIND_RETRANS, r_own, r_own_count,
                                                     32'd0, miss_mask, 1'b0);
                                    r_pend_valid <= 1'b1;
                                    r_state      <= S_FLUSH;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                S_HIST: begin
                    if (seen_rdata[0]) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_latest  <= r_latest + 32'd1;
                        r_key_seq <= r_latest + 32'd1;
                        r_key_snd <= r_peer;
                        r_key_msg <= r_msg;
                        r_key_del <= 1'b0;
                        r_state   <= S_HSCAN;
                    end
                end

                S_ACKSCAN: begin
                    r_best <= ack_best_c;
                    if (scan_last) begin
                        r_key_seq   <= ack_best_c;
                        r_key_snd   <= r_own;
                        r_key_msg   <= r_own_count;
                        r_key_del   <= 1'b1;
                        r_do_remove <= 1'b1;
                        r_cnt       <= '0;
                        r_state     <= S_HSCAN;
                    end
                end

                S_HSCAN: begin
                    if (r_rdv) begin
                        if (vj && hd.seq == r_key_seq && hd.sender == r_key_snd && !r_m_found)
                        begin
                            r_m_found <= 1'b1;
                            r_m_idx   <= hj;
                        end
                        if (!vj && !r_f_found) begin
                            r_f_found <= 1'b1;
                            r_f_idx   <= hj;
                        end
                        if (r_do_remove && vj && hd.sender == r_key_snd && hd.msg == r_key_msg
                            && (!r_r_found || hd.seq < r_r_seq)) begin
                            r_r_found <= 1'b1;
                            r_r_idx   <= hj;
                            r_r_seq   <= hd.seq;
                        end
                    end
                    if (scan_last) r_state <= S_HWRITE;
                end

                S_HWRITE: begin
                    r_hvalid  <= hv_wr;
                    r_ok      <= ok_c;
                    r_cnt     <= '0;
                    r_rdv     <= 1'b0;
                    r_b_found <= 1'b0;
                    unique case (r_op)
                        toms_pkg::OP_SEND: begin
                            r_pend <= mk_res(toms_pkg::KIND_DATA, r_own, r_own_count,
                                             32'd0, 16'd0, !ok_c);
                            r_pend_valid <= 1'b1;
                            r_state      <= S_FLUSH;
                        end
                        toms_pkg::OP_DATA: begin
                            r_pend <= mk_res(toms_pkg::KIND_ACK, r_peer, r_msg,
                                             r_latest, 16'd0, !ok_c);
                            r_pend_valid <= 1'b1;
                            r_state      <= S_FLUSH;
                        end
                        toms_pkg::OP_ACK: begin
                            r_pend <= mk_res(toms_pkg::KIND_FINAL, r_own, r_own_count,
                                             r_key_seq, 16'd0, !ok_c);
                            r_pend_valid <= 1'b1;
                            r_state      <= S_DSCAN;
                        end
                        default: begin
                            r_state <= S_DSCAN;
                        end
                    endcase
                end

                S_DSCAN: begin
                    if (r_rdv && vj && (!r_b_found || hd.seq < r_b_seq ||
                        (hd.seq == r_b_seq && hd.sender < r_b_snd))) begin
                        r_b_found <= 1'b1;
                        r_b_idx   <= hj;
                        r_b_seq   <= hd.seq;
                        r_b_snd   <= hd.sender;
                        r_b_msg   <= hd.msg;
                        r_b_del   <= hd.deliverable;
                    end
                    if (scan_last) r_state <= S_DEMIT;
                end

                S_DEMIT: begin
                    if (r_b_found && r_b_del) begin
                        // deliver the head and sweep again
                        if (can_emit) begin
                            if (r_pend_valid) begin
                                r_out       <= r_pend;
                                r_out_valid <= 1'b1;
                            end
                            r_pend <= mk_res(toms_pkg::KIND_DELIVER, r_b_snd, r_b_msg,
                                             r_b_seq, 16'd0, !r_ok);
                            r_pend_valid       <= 1'b1;
                            r_hvalid[r_b_idx]  <= 1'b0;
                            r_any_deliv        <= 1'b1;
                            r_b_found          <= 1'b0;
                            r_cnt              <= '0;
                            r_rdv              <= 1'b0;
                            r_state            <= S_DSCAN;
                        end
                    end else begin
                        // close the final-seq work
                        if (r_key_seq > r_latest) r_latest <= r_key_seq;
                        if (r_op == toms_pkg::OP_ACK) begin
                            r_may_orig  <= 1'b1;
                            r_ack_seen  <= '0;
                            r_ack_total <= '0;
                            r_awaiting  <= 1'b0;
                        end
                        if (r_op == toms_pkg::OP_FINAL && !r_ok && !r_any_deliv) begin
                            r_pend <= mk_res(toms_pkg::KIND_FINAL, r_peer, r_msg, r_val,
                                             16'd0, 1'b1);
                            r_pend_valid <= 1'b1;
                        end
                        r_state <= S_FLUSH;
                    end
                end

                S_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        // flag the last beat of the event
                        r_out        <= toms_pkg::t_out_item'({r_pend[OW-1:1], 1'b1});
                        r_out_valid  <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `TOMS_ASSERT(a_ack_count, 32'(r_ack_total) == $countones(r_ack_seen), "ack count off")
    `TOMS_ASSERT_IMP(a_idle_acks, !r_awaiting, r_ack_seen == '0, "ack record not cleared")
    `TOMS_ASSERT_IMP(a_ready_empty, o_in_ready, !r_pend_valid, "result left behind at idle")

endmodule

>>> src/toms_ram.sv
module toms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
